// ===== design/mpo_pkg.sv =====
// ----------------------------------------------------------------------------
// mpo_pkg: shared types and constants for the perturb-and-observe tracker
// Field widths, register indexes, control modes, fixed-point reciprocals and
// the structs that travel between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package mpo_pkg;

   // field widths
   localparam int CUR_W   = 16;
   localparam int VOLTS_W = 6;
   localparam int ADC_W   = 10;
   localparam int DUTY_W  = 8;
   localparam int WATT_W  = 12;
   localparam int TREND_W = 2;
   localparam int MODE_W  = 2;
   localparam int TICK_W  = 16;
   localparam int MAXW_W  = 11;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // averaging window
   localparam int AVERAGE_COUNT = 5;
   localparam int IDX_W   = (AVERAGE_COUNT > 1) ? $clog2(AVERAGE_COUNT) : 1;
   localparam int SUM_W   = WATT_W + $clog2(AVERAGE_COUNT) + 1;
   localparam int AVG_SHIFT   = 18;
   localparam int AVG_RECIP_W = AVG_SHIFT + 1;
   localparam logic [AVG_RECIP_W-1:0] AVG_RECIP =
      AVG_RECIP_W'(((2 ** AVG_SHIFT) + AVERAGE_COUNT - 1) / AVERAGE_COUNT);
   localparam int AVG_PROD_W = SUM_W + AVG_RECIP_W;

   // volts * mA product and divide by 1000 through a reciprocal
   localparam int PROD_W     = VOLTS_W + CUR_W;       // signed product
   localparam int MAG_W      = PROD_W - 1;            // magnitude bound 2^21
   localparam int DIV_SHIFT  = 31;
   localparam int RECIP_W    = 22;
   localparam logic [RECIP_W-1:0] RECIP_1000 =
      RECIP_W'((64'd2147483648 + 64'd999) / 64'd1000);
   localparam int RQ_W       = MAG_W + RECIP_W;
   localparam int QUOT_W     = RQ_W - DIV_SHIFT;

   localparam logic signed [WATT_W-1:0] WATT_MAX = 12'sh7FF;
   localparam logic signed [WATT_W-1:0] WATT_MIN = 12'sh800;
   localparam logic [DUTY_W-1:0] DUTY_TOP = '1;

   // reset values of the registers
   localparam logic [TICK_W-1:0] TICK_PERIOD_RESET = 16'd500;
   localparam logic [MAXW_W-1:0] MAX_WATTS_RESET   = 11'd10;

   // queue between front and back
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   typedef enum logic [MODE_W-1:0] {
      MODE_SEARCH = 2'd0,
      MODE_SWEEP  = 2'd1,
      MODE_HOLD   = 2'd2
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CONTROL_MODE    = 3'd0,
      REG_TICK_PERIOD     = 3'd1,
      REG_TARGET_VOLTS    = 3'd2,
      REG_MAX_WATTS       = 3'd3,
      REG_INPUT_SENSE_EN  = 3'd4,
      REG_INPUT_THRESHOLD = 3'd5
   } reg_index_type;

   typedef enum logic [TREND_W-1:0] {
      TREND_NONE     = 2'd0,
      TREND_DROP     = 2'd1,
      TREND_INCREASE = 2'd2
   } trend_type;

   typedef struct packed {
      logic [MODE_W-1:0]  control_mode;
      logic [TICK_W-1:0]  tick_period;
      logic [VOLTS_W-1:0] target_volts;
      logic [MAXW_W-1:0]  max_watts;
      logic               input_sense_enable;
      logic [ADC_W-1:0]   input_threshold_counts;
   } cfg_type;

   // one control update handed from front to back
   typedef struct packed {
      logic signed [CUR_W-1:0] held_current;
      logic [VOLTS_W-1:0]      held_volts;
      logic                    in_low;
   } upd_type;

endpackage

`default_nettype wire

// ===== design/mpo_if.sv =====
// ----------------------------------------------------------------------------
// mpo_if: valid/ready channel interfaces of the tracker
// Tick word in, update result word out, and the register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpo_req_if import mpo_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic signed [CUR_W-1:0] bus_current_ma;
   logic [VOLTS_W-1:0]      bus_volts;
   logic [ADC_W-1:0]        input_adc;

   modport source (output valid, bus_current_ma, bus_volts, input_adc, input ready);
   modport sink   (input valid, bus_current_ma, bus_volts, input_adc, output ready);
endinterface

interface mpo_rsp_if import mpo_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic [DUTY_W-1:0]        pwm_duty;
   logic signed [WATT_W-1:0] avg_watts;
   logic signed [WATT_W-1:0] peak_watts;
   logic [TREND_W-1:0]       trend;
   logic                     over_limit;
   logic                     input_low;

   modport source (output valid, pwm_duty, avg_watts, peak_watts, trend, over_limit,
                   input_low, input ready);
   modport sink   (input valid, pwm_duty, avg_watts, peak_watts, trend, over_limit,
                   input_low, output ready);
endinterface

interface mpo_csr_if import mpo_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/mpo_front.sv =====
// ----------------------------------------------------------------------------
// mpo_front: tick counter and sample latch
// Takes one tick word per cycle unless the queue is full, counts toward the
// update period, latches current and volts, queues a word per control update.
// ----------------------------------------------------------------------------
`default_nettype none

module mpo_front import mpo_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   mpo_req_if.sink    req_ch,
   input  logic       queue_full,
   output logic       push,
   output upd_type    push_data
);

   logic [TICK_W-1:0]       tick_count_ff, tick_count_in;
   logic signed [CUR_W-1:0] held_current_ff, held_current_in;
   logic [VOLTS_W-1:0]      held_volts_ff, held_volts_in;
   logic [TICK_W:0]         tick_next;
   logic                    accept;
   logic                    fire;
   logic                    cur_nz;
   logic                    in_low;

   assign req_ch.ready = !queue_full;
   assign accept       = req_ch.valid && req_ch.ready;

   // period check: the count may sit above a freshly lowered period
   assign tick_next = {1'b0, tick_count_ff} + {{TICK_W{1'b0}}, 1'b1};
   assign fire      = tick_next >= {1'b0, cfg.tick_period};

   // latch rules: nonzero current, volts only with nonzero current too
   assign cur_nz = req_ch.bus_current_ma != '0;

   always_comb begin
      tick_count_in   = tick_count_ff;
      held_current_in = held_current_ff;
      held_volts_in   = held_volts_ff;
      if (accept) begin
         tick_count_in = fire ? '0 : tick_next[TICK_W-1:0];
         if (fire && cur_nz) begin
            held_current_in = req_ch.bus_current_ma;
            if (req_ch.bus_volts != '0) begin
               held_volts_in = req_ch.bus_volts;
            end
         end
      end
   end

   // without sensing the input always reads as low
   assign in_low = !cfg.input_sense_enable ||
                   (req_ch.input_adc < cfg.input_threshold_counts);

   assign push                   = accept && fire;
   assign push_data.held_current = held_current_in;
   assign push_data.held_volts   = held_volts_in;
   assign push_data.in_low       = in_low;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff   <= '0;
         held_current_ff <= '0;
         held_volts_ff   <= '0;
      end else begin
         tick_count_ff   <= tick_count_in;
         held_current_ff <= held_current_in;
         held_volts_ff   <= held_volts_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/mpo_queue.sv =====
// ----------------------------------------------------------------------------
// mpo_queue: short update queue
// First-word-fall-through queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mpo_queue import mpo_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  upd_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    pop_valid,
   output upd_type pop_data
);

   upd_type              mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full      = count_ff == Q_CNT_W'(Q_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== design/mpo_back.sv =====
// ----------------------------------------------------------------------------
// mpo_back: power pipeline and duty control
// Five stages: volts x current, reciprocal divide by 1000, saturate,
// five-sample average, then peak tracking and duty update into the output
// register. The whole pipeline advances when the output word can move.
// ----------------------------------------------------------------------------
`default_nettype none

module mpo_back import mpo_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     q_valid,
   input  upd_type  q_data,
   output logic     q_pop,
   mpo_rsp_if.source rsp_ch
);

   logic en;

   // stage 1: signed product
   logic                     s1_valid_ff;
   logic signed [PROD_W-1:0] s1_prod_ff, s1_prod_in;
   logic [VOLTS_W-1:0]       s1_volts_ff;
   logic                     s1_in_low_ff;

   // stage 2: magnitude times reciprocal
   logic                     s2_valid_ff;
   logic                     s2_neg_ff;
   logic [RQ_W-1:0]          s2_rq_ff, s2_rq_in;
   logic [MAG_W-1:0]         s2_mag;
   logic [VOLTS_W-1:0]       s2_volts_ff;
   logic                     s2_in_low_ff;

   // stage 3: saturated watts
   logic                     s3_valid_ff;
   logic signed [WATT_W-1:0] s3_watts_ff, s3_watts_in;
   logic [QUOT_W-1:0]        s3_quot;
   logic [VOLTS_W-1:0]       s3_volts_ff;
   logic                     s3_in_low_ff;

   // stage 4: averaging window
   logic                     s4_valid_ff;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic signed [SUM_W-1:0]  acc_ff, acc_in;
   logic signed [WATT_W-1:0] avg_ff, avg_in;
   logic                     last_sample;
   logic [SUM_W-1:0]         sum_mag;
   logic [AVG_PROD_W-1:0]    avg_prod;
   logic [WATT_W:0]          avg_quot;
   logic [VOLTS_W-1:0]       s4_volts_ff;
   logic                     s4_in_low_ff;

   // stage 5: control state and output word
   logic                     rsp_valid_ff;
   logic signed [WATT_W-1:0] rsp_avg_ff;
   logic signed [WATT_W-1:0] peak_ff, peak_in;
   logic signed [WATT_W-1:0] prev_ff, prev_in;
   logic [DUTY_W-1:0]        duty_ff, duty_in;
   logic                     down_ff, down_in;
   logic [TREND_W-1:0]       trend_ff, trend_in;
   logic                     over_ff, over_in;
   logic                     low_ff, low_in;
   logic                     drop;
   logic                     over;
   logic                     step_down;

   assign en    = !rsp_valid_ff || rsp_ch.ready;
   assign q_pop = en && q_valid;

   // stage 1
   assign s1_prod_in = PROD_W'($signed({1'b0, q_data.held_volts})) *
                       PROD_W'($signed(q_data.held_current));

   // stage 2: magnitude stays below 2^21
   assign s2_mag   = MAG_W'(s1_prod_ff[PROD_W-1] ? -s1_prod_ff : s1_prod_ff);
   assign s2_rq_in = RQ_W'(s2_mag) * RQ_W'(RECIP_1000);

   // stage 3: truncate toward zero, then clip to 12 bits
   assign s3_quot = s2_rq_ff[RQ_W-1 -: QUOT_W];
   always_comb begin
      if (s2_neg_ff) begin
         s3_watts_in = s3_quot[WATT_W-1] ? WATT_MIN : WATT_W'(-s3_quot);
      end else begin
         s3_watts_in = s3_quot[WATT_W-1] ? WATT_MAX : $signed(s3_quot[WATT_W-1:0]);
      end
   end

   // stage 4: running sum over the window, divide by the count on the last
   assign last_sample = idx_ff == IDX_W'(AVERAGE_COUNT - 1);
   assign acc_in      = ((idx_ff == '0) ? '0 : acc_ff) + SUM_W'(s3_watts_ff);
   assign sum_mag     = SUM_W'(acc_in[SUM_W-1] ? -acc_in : acc_in);
   assign avg_prod    = AVG_PROD_W'(sum_mag) * AVG_PROD_W'(AVG_RECIP);
   assign avg_quot    = avg_prod[AVG_SHIFT +: WATT_W+1];
   assign idx_in      = last_sample ? '0 : idx_ff + 1'b1;
   assign avg_in      = last_sample ?
                        WATT_W'(acc_in[SUM_W-1] ? -avg_quot : avg_quot) : avg_ff;

   // stage 5: peak, search decision, sweep and clamp
   assign drop = (avg_ff > 0) && (avg_ff < prev_ff);
   assign over = (s4_volts_ff > cfg.target_volts) ||
                 ($signed({avg_ff[WATT_W-1], avg_ff}) > $signed({2'b00, cfg.max_watts}));
   assign step_down = drop || over || s4_in_low_ff;

   always_comb begin
      peak_in  = (avg_ff > peak_ff) ? avg_ff : peak_ff;
      prev_in  = prev_ff;
      duty_in  = duty_ff;
      down_in  = down_ff;
      trend_in = trend_ff;
      over_in  = over_ff;
      low_in   = low_ff;
      if (cfg.control_mode == MODE_SEARCH) begin
         prev_in  = avg_ff;
         trend_in = drop ? TREND_DROP : TREND_INCREASE;
         over_in  = over;
         low_in   = s4_in_low_ff;
         if (step_down) begin
            duty_in = (duty_ff == '0) ? '0 : duty_ff - 1'b1;
         end else begin
            duty_in = (duty_ff == DUTY_TOP) ? DUTY_TOP : duty_ff + 1'b1;
         end
      end else if (cfg.control_mode == MODE_SWEEP) begin
         if (duty_ff == DUTY_TOP) begin
            down_in = 1'b1;
         end else if (duty_ff == '0) begin
            down_in = 1'b0;
         end
         duty_in = down_in ? duty_ff - 1'b1 : duty_ff + 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         avg_ff       <= '0;
         peak_ff      <= '0;
         prev_ff      <= '0;
         duty_ff      <= '0;
         down_ff      <= 1'b0;
         trend_ff     <= TREND_NONE;
         over_ff      <= 1'b0;
         low_ff       <= 1'b0;
      end else if (en) begin
         s1_valid_ff  <= q_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         rsp_valid_ff <= s4_valid_ff;
         if (s3_valid_ff) begin
            idx_ff <= idx_in;
            avg_ff <= avg_in;
         end
         if (s4_valid_ff) begin
            peak_ff  <= peak_in;
            prev_ff  <= prev_in;
            duty_ff  <= duty_in;
            down_ff  <= down_in;
            trend_ff <= trend_in;
            over_ff  <= over_in;
            low_ff   <= low_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (en) begin
         s1_prod_ff   <= s1_prod_in;
         s1_volts_ff  <= q_data.held_volts;
         s1_in_low_ff <= q_data.in_low;
         s2_neg_ff    <= s1_prod_ff[PROD_W-1];
         s2_rq_ff     <= s2_rq_in;
         s2_volts_ff  <= s1_volts_ff;
         s2_in_low_ff <= s1_in_low_ff;
         s3_watts_ff  <= s3_watts_in;
         s3_volts_ff  <= s2_volts_ff;
         s3_in_low_ff <= s2_in_low_ff;
         s4_volts_ff  <= s3_volts_ff;
         s4_in_low_ff <= s3_in_low_ff;
         rsp_avg_ff   <= avg_ff;
         if (s3_valid_ff) begin
            acc_ff <= acc_in;
         end
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.pwm_duty   = duty_ff;
   assign rsp_ch.avg_watts  = rsp_avg_ff;
   assign rsp_ch.peak_watts = peak_ff;
   assign rsp_ch.trend      = trend_ff;
   assign rsp_ch.over_limit = over_ff;
   assign rsp_ch.input_low  = low_ff;

   // window index stays inside the window
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= IDX_W'(AVERAGE_COUNT - 1))
      else $error("sample index out of window");

   // peak never below the average it reports with
   a_peak_ge_avg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (peak_ff >= rsp_avg_ff))
      else $error("peak below average");

   // duty moves by at most one step per update
   a_duty_step: assert property (@(posedge clock) disable iff (reset)
      (en && s4_valid_ff) |=> (duty_ff == $past(duty_ff) ||
                               duty_ff == $past(duty_ff) + 8'd1 ||
                               duty_ff == $past(duty_ff) - 8'd1))
      else $error("duty jumped");

   // hold mode leaves the duty alone
   a_hold_duty: assert property (@(posedge clock) disable iff (reset)
      (en && s4_valid_ff && cfg.control_mode != MODE_SEARCH &&
       cfg.control_mode != MODE_SWEEP) |=> (duty_ff == $past(duty_ff)))
      else $error("duty changed in hold mode");

endmodule

`default_nettype wire

// ===== design/mppt_perturb_observe_top.sv =====
// ----------------------------------------------------------------------------
// mppt_perturb_observe_top: perturb-and-observe maximum power point tracker
// Counts tick words and runs one duty update every tick_period ticks.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one tick word per accepted transfer: output current (mA),
//   bus volts and input ADC count; one word per cycle while the queue has room.
//   Every tick_period-th tick causes exactly one rsp_ch word (new duty,
//   average and peak watts, trend and limit flags); all other ticks give none.
//   csr_ch writes the six control registers by index and is always ready; the
//   user must write it only while the tracker is idle (block does not check).
//   The result word of an update tick passes the power pipeline stages in
//   order (multiply, divide by 1000, clip, average, control). Throughput is
//   one tick per cycle and one update per cycle while rsp_ch is not stalled,
//   set by the five-stage power pipeline.
//   A two-word queue sits between the tick counter and the pipeline. When
//   the receiver stalls, the pipeline holds, the queue fills and req_ch.ready
//   drops once two updates wait; ticks that cause no update are held back too.
//   Reset (synchronous, active high) restores the register defaults and
//   clears the counter, held readings, average, peak, duty and flags.
// ----------------------------------------------------------------------------
`default_nettype none

module mppt_perturb_observe_top import mpo_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   mpo_req_if.sink    req_ch,
   mpo_rsp_if.source  rsp_ch,
   mpo_csr_if.sink    csr_ch
);

   cfg_type cfg_ff, cfg_in;
   logic    push;
   upd_type push_data;
   logic    queue_full;
   logic    q_pop;
   logic    q_valid;
   upd_type q_data;

   // register file write
   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_CONTROL_MODE:    cfg_in.control_mode = csr_ch.data[MODE_W-1:0];
            REG_TICK_PERIOD:     cfg_in.tick_period  = csr_ch.data[TICK_W-1:0];
            REG_TARGET_VOLTS:    cfg_in.target_volts = csr_ch.data[VOLTS_W-1:0];
            REG_MAX_WATTS:       cfg_in.max_watts    = csr_ch.data[MAXW_W-1:0];
            REG_INPUT_SENSE_EN:  cfg_in.input_sense_enable = csr_ch.data[0];
            REG_INPUT_THRESHOLD: cfg_in.input_threshold_counts = csr_ch.data[ADC_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.control_mode           <= MODE_SEARCH;
         cfg_ff.tick_period            <= TICK_PERIOD_RESET;
         cfg_ff.target_volts           <= '0;
         cfg_ff.max_watts              <= MAX_WATTS_RESET;
         cfg_ff.input_sense_enable     <= 1'b0;
         cfg_ff.input_threshold_counts <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mpo_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   mpo_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_data)
   );

   mpo_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_valid (q_valid),
      .q_data  (q_data),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

`default_nettype wire
